// File: rtl/pva_pkg.sv
`timescale 1ns / 1ps

package pva_pkg;

    // sizes
    localparam int VOICE_COUNT_DEF = 24;
    localparam int MAXV_W          = 5;
    localparam int VOICE_W         = 5;
    localparam int PRIO_W          = 8;
    localparam int LEVEL_W         = 16;
    localparam int AGE_W           = 16;
    localparam int GEN_W           = 32;

    // register reset and scan seed
    localparam logic [MAXV_W-1:0]  MAX_VOICES_RESET = 5'd24;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 16'hffff;

    // item command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // input item
    typedef struct packed {
        logic               cmd;
        logic [PRIO_W-1:0]  priority_req;
        logic [VOICE_W-1:0] voice_index;
        logic               busy_req;
        logic [LEVEL_W-1:0] level;
    } t_in_item;

    // result item
    typedef struct packed {
        logic               granted;
        logic [VOICE_W-1:0] voice;
        logic               stolen;
        logic [GEN_W-1:0]   generation;
    } t_out_item;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_GRANT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan;
        logic write;
        logic grant;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
    } t_dp_status;

endpackage

// File: rtl/pva_ctrl.sv
`timescale 1ns / 1ps

module pva_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_is_write,
    input  logic                i_out_stall,
    input  pva_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output pva_pkg::t_dp_cmd    o_cmd
);
    import pva_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // result slot can take a new item this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_in_is_write ? ST_WRITE : ST_SCAN;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    o_cmd.write = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_end) begin
                    n_state = ST_GRANT;
                end
            end
            ST_GRANT: begin
                if (out_free) begin
                    o_cmd.grant = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid follows loads and downstream takes
    always_comb begin
        if (o_cmd.write || o_cmd.grant) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/pva_dp.sv
`timescale 1ns / 1ps

module pva_dp #(
    parameter int VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pva_pkg::MAXV_W-1:0] i_cfg_data,
    input  pva_pkg::t_in_item          i_in_item,
    input  pva_pkg::t_dp_cmd           i_cmd,
    output pva_pkg::t_dp_status        o_status,
    output pva_pkg::t_out_item         o_out_item
);
    import pva_pkg::*;

    localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CW = $clog2(VOICE_COUNT + 1);
    localparam int WW = CW + MAXV_W;
    localparam int XW = IW + VOICE_W;

    // per-voice state
    logic               r_busy  [VOICE_COUNT];
    logic [LEVEL_W-1:0] r_level [VOICE_COUNT];
    logic [PRIO_W-1:0]  r_prio  [VOICE_COUNT];
    logic [AGE_W-1:0]   r_age   [VOICE_COUNT];
    logic [GEN_W-1:0]   r_gen   [VOICE_COUNT];

    // configuration
    logic [MAXV_W-1:0]  r_max_voices;

    // latched item
    logic [PRIO_W-1:0]  r_req_prio;
    logic [VOICE_W-1:0] r_req_vidx;
    logic               r_req_busy;
    logic [LEVEL_W-1:0] r_req_level;

    // scan state
    logic [CW-1:0]      r_idx;
    logic [PRIO_W-1:0]  r_best_prio;
    logic [LEVEL_W-1:0] r_best_level;
    logic [AGE_W-1:0]   r_cand_age;
    logic [IW-1:0]      r_cand;
    logic               r_have_cand;
    logic [IW-1:0]      r_free_idx;
    logic               r_have_free;

    t_out_item          r_out;

    logic [WW-1:0]      idx_w;
    logic [WW-1:0]      max_w;
    logic [WW-1:0]      vc_w;
    logic [WW-1:0]      elig_w;
    logic               in_range;
    logic [IW-1:0]      cur;
    logic               cur_busy;
    logic [LEVEL_W-1:0] cur_level;
    logic [PRIO_W-1:0]  cur_prio;
    logic [AGE_W-1:0]   cur_age;
    logic               is_free;
    logic               better;
    logic [XW-1:0]      vidx_w;
    logic               wr_ok;
    logic [IW-1:0]      wr_idx;
    logic [IW-1:0]      sel;
    logic [XW-1:0]      sel_w;
    logic               has;
    logic [GEN_W-1:0]   gen_next;

    // eligible voice count, clamped to the voice count
    assign idx_w  = {{MAXV_W{1'b0}}, r_idx};
    assign max_w  = {{CW{1'b0}}, r_max_voices};
    assign vc_w   = WW'(VOICE_COUNT);
    assign elig_w = (max_w > vc_w) ? vc_w : max_w;

    // current voice under scan
    assign in_range  = idx_w < elig_w;
    assign cur       = r_idx[IW-1:0];
    assign cur_busy  = r_busy[cur];
    assign cur_level = r_level[cur];
    assign cur_prio  = r_prio[cur];
    assign cur_age   = r_age[cur];
    assign is_free   = !cur_busy && (cur_level == '0);
    assign better    = (cur_prio < r_best_prio) ||
                       ((cur_prio == r_best_prio) &&
                        ((cur_level < r_best_level) ||
                         ((cur_level == r_best_level) && (cur_age > r_cand_age))));

    assign o_status.scan_end = !in_range || is_free;

    // write target
    assign vidx_w = {{IW{1'b0}}, r_req_vidx};
    assign wr_ok  = vidx_w < XW'(VOICE_COUNT);
    assign wr_idx = vidx_w[IW-1:0];

    // granted voice
    assign has      = r_have_free || r_have_cand;
    assign sel      = r_have_free ? r_free_idx : r_cand;
    assign sel_w    = {{VOICE_W{1'b0}}, sel};
    assign gen_next = r_gen[sel] + GEN_W'(1);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_voices <= MAX_VOICES_RESET;
        end else if (i_cfg_we) begin
            r_max_voices <= i_cfg_data;
        end
    end

    // item latch and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_prio   <= i_in_item.priority_req;
            r_req_vidx   <= i_in_item.voice_index;
            r_req_busy   <= i_in_item.busy_req;
            r_req_level  <= i_in_item.level;
            r_idx        <= '0;
            r_best_prio  <= i_in_item.priority_req;
            r_best_level <= LEVEL_MAX;
            r_cand_age   <= '0;
            r_have_cand  <= 1'b0;
            r_have_free  <= 1'b0;
        end else if (i_cmd.scan && in_range) begin
            if (is_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= cur;
            end else begin
                if (better) begin
                    r_best_prio  <= cur_prio;
                    r_best_level <= cur_level;
                    r_cand_age   <= cur_age;
                    r_cand       <= cur;
                    r_have_cand  <= 1'b1;
                end
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    // voice state: status writes and grant update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_busy[i]  <= 1'b0;
                r_level[i] <= '0;
                r_prio[i]  <= '0;
                r_age[i]   <= '0;
                r_gen[i]   <= '0;
            end
        end else begin
            if (i_cmd.write && wr_ok) begin
                r_busy[wr_idx]  <= r_req_busy;
                r_level[wr_idx] <= r_req_level;
                r_prio[wr_idx]  <= r_req_prio;
            end
            if (i_cmd.grant && has) begin
                for (int i = 0; i < VOICE_COUNT; i++) begin
                    if (WW'(i) < elig_w) begin
                        r_age[i] <= r_age[i] + AGE_W'(1);
                    end
                end
                r_age[sel]  <= '0;
                r_prio[sel] <= r_req_prio;
                r_gen[sel]  <= gen_next;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.grant) begin
            r_out.granted    <= has;
            r_out.voice      <= has ? sel_w[VOICE_W-1:0] : '0;
            r_out.stolen     <= has && !r_have_free;
            r_out.generation <= has ? gen_next : '0;
        end else if (i_cmd.write) begin
            r_out <= '0;
        end
    end

    assign o_out_item = r_out;

endmodule

// File: rtl/priority_voice_allocator.sv
`timescale 1ns / 1ps

// Priority voice allocator with voice stealing. An allocate item scans the
// eligible voices one per cycle, stopping at the first free voice, and
// otherwise takes the lowest-priority voice no higher than the request (ties
// by lower level, then greater age). A write item is captured, then writes
// the voice state and loads a no-grant result once the output register is
// free; an allocate item is captured, scanned voice by voice until a free
// voice is found or the eligible voices run out, then granted, and its result
// is loaded once the output register is free. The scan runs over the voice
// state registers. One item is worked on at a time; the input stalls from
// acceptance until the result is loaded, and a new item is taken while a
// finished result still waits in the output register. The voice state is
// cleared by reset at once, with no clearing pass.
module priority_voice_allocator #(
    parameter int VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pva_pkg::MAXV_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pva_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pva_pkg::t_out_item         o_out_item
);
    import pva_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer
    pva_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_is_write (i_in_item.cmd == CMD_WRITE),
        .i_out_stall   (i_out_stall),
        .i_status      (dp_status),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_cmd         (dp_cmd)
    );

    // voice state and scan datapath
    pva_dp #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_item  (i_in_item),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_out_item (o_out_item)
    );

endmodule

// File: rtl/pva_checker.sv
`timescale 1ns / 1ps

module pva_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input pva_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input pva_pkg::t_out_item o_out_item
);
    import pva_pkg::*;

    // reset leaves the block empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // a write item accepted with an empty result slot gives a no-grant result after the write state
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.cmd == CMD_WRITE) && !o_out_valid
        |=> ##1 o_out_valid && !o_out_item.granted)
        else $error("write item result missing or granted");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind priority_voice_allocator pva_checker u_pva_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
